// ----- sv/gws_pkg.sv -----
package gws_pkg;

  localparam int IMAGE_WIDTH = 512;
  localparam int COL_W = $clog2(IMAGE_WIDTH);
  localparam int ROW_W = 12;
  localparam int ROWS_CFG_W = 13;
  localparam int PIX_W = 8;
  localparam int WT_W = 32;
  localparam int VAL_W = 16;
  localparam int OUT_COL_W = 9;
  localparam int MEM_AW = COL_W + 2;
  localparam int MEM_DEPTH = 4 * (2 ** COL_W);

  localparam int NUM_W = 44;
  localparam int DEN_W = 36;

  localparam int QUEUE_DEPTH = 32;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 13'd512;
  localparam logic [ROWS_CFG_W-1:0] ROWS_MIN = 13'd3;
  localparam logic [ROWS_CFG_W-1:0] ROWS_MAX = 13'd4096;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [33:0] ONE_Q32 = 34'h1_0000_0000;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
  } result_t;

endpackage

// ----- sv/gradient_weighted_smoothing_3x3.sv -----
// Channel  Dir  Handshake                    Beat contents
// pixel    in   pixel_valid / pixel_stall    pixel, frame_start
// result   out  result_valid / result_stall  out_row, out_col, smoothed, last_of_run
// config   in   wr_en                        wr_data (rows per frame)
//
// A beat that needs a weight computes two 25-step square roots and 12 series terms, each a
// multiply and a divide by the term index. Each neighborhood sum takes nine reads, a 16-step
// divide and one queue push per result. Reset clears the counters and the result queue and
// sets 512 rows; the line memories are not cleared. A new pixel beat is taken only after the
// output phase has passed on four queued results or emptied the queue.
// result_stall holds the block in its output phase.
module gradient_weighted_smoothing_3x3 import gws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  frame_start,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [ROW_W-1:0]      out_row,
  output logic [OUT_COL_W-1:0]  out_col,
  output logic [VAL_W-1:0]      smoothed,
  output logic                  last_of_run,
  input  logic                  wr_en,
  input  logic [ROWS_CFG_W-1:0] wr_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_WCALC = 9'b000000100,
    S_WWR   = 9'b000001000,
    S_ESEL  = 9'b000010000,
    S_MAC   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_PUSH  = 9'b010000000,
    S_DRAIN = 9'b100000000
  } state_t;

  state_t state;

  logic [ROWS_CFG_W-1:0] image_rows, rows_c;
  logic [ROW_W-1:0] rows_m1, rows_m2;
  logic [ROW_W-1:0] row_count, y0, y, ym1, ym2, y0m1;
  logic [COL_W-1:0] col_count, x0, x, ec;
  logic [PIX_W-1:0] cur_pix, pa, pb;
  logic pix_acc, res_acc, last_col, calc0;
  logic emit_a, emit_b;
  logic [ROW_W-1:0] er;
  logic [VAL_W-1:0] val;
  logic [WT_W-1:0] wt_val;
  logic [1:0] rd_cnt;

  logic [PIX_W-1:0] pixel_mem [MEM_DEPTH];
  logic [WT_W-1:0] weight_mem [MEM_DEPTH];
  logic [MEM_AW-1:0] pix_raddr, tap_addr;
  logic [PIX_W-1:0] pix_rd;
  logic [WT_W-1:0] wt_rd, wt_eff;
  logic wt_we;

  logic [3:0] tap;
  logic [1:0] ti, tj;
  logic [ROW_W-1:0] rr;
  logic [COL_W-1:0] cc;
  logic wz_now, wz1;
  logic [39:0] prod;
  logic [WT_W-1:0] wq;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;

  logic signed [8:0] gx, gy;
  logic w_start, w_done;
  logic [WT_W-1:0] w_out;
  logic d_start, d_done;
  logic [VAL_W-1:0] d_quot;

  logic [ROW_W-1:0] drl [3];
  logic [ROW_W-1:0] drl_n [3];
  logic [COL_W-1:0] dcl [2];
  logic [COL_W-1:0] dcl_n [2];
  logic [1:0] nr_last, nr_last_n, pi;
  logic nc_last, nc_last_n, pj;

  result_t push_data, head_data;
  logic push_valid;
  logic [QUEUE_CW-1:0] qcount;
  logic [1:0] dcount;

  always_comb begin
    if (image_rows < ROWS_MIN) begin
      rows_c = ROWS_MIN;
    end else if (image_rows > ROWS_MAX) begin
      rows_c = ROWS_MAX;
    end else begin
      rows_c = image_rows;
    end
  end
  assign rows_m1 = ROW_W'(rows_c - ROWS_CFG_W'(1));
  assign rows_m2 = ROW_W'(rows_c - ROWS_CFG_W'(2));

  assign pix_acc = pixel_valid && !pixel_stall;
  assign pixel_stall = (state != S_IDLE);
  assign y0 = frame_start ? '0 : row_count;
  assign x0 = frame_start ? '0 : col_count;
  assign y0m1 = y0 - ROW_W'(1);
  assign last_col = (x0 == COL_W'(IMAGE_WIDTH - 1));
  assign calc0 = (y0 >= ROW_W'(2)) && (y0m1 <= rows_m2) && (x0 >= COL_W'(1))
                 && (x0 <= COL_W'(IMAGE_WIDTH - 2));

  assign ym1 = y - ROW_W'(1);
  assign ym2 = y - ROW_W'(2);
  assign ec = x - COL_W'(1);

  assign rr = er + ROW_W'(ti) - ROW_W'(1);
  assign cc = ec + COL_W'(tj) - COL_W'(1);
  assign tap_addr = {rr[1:0], cc};
  assign wz_now = (rr == '0) || (rr >= rows_m1) || (cc == '0)
                  || (cc >= COL_W'(IMAGE_WIDTH - 1));

  always_comb begin
    case (state)
      S_RD: begin
        case (rd_cnt)
          2'd0: pix_raddr = {ym1[1:0], COL_W'(x + COL_W'(1))};
          2'd1: pix_raddr = {ym1[1:0], ec};
          default: pix_raddr = {ym2[1:0], x};
        endcase
      end
      default: pix_raddr = tap_addr;
    endcase
  end

  assign wt_we = (state == S_WWR);

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      pixel_mem[{y0[1:0], x0}] <= pixel;
    end
    pix_rd <= pixel_mem[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      weight_mem[{ym1[1:0], x}] <= wt_val;
    end
    wt_rd <= weight_mem[tap_addr];
  end

  assign gx = $signed({1'b0, pa}) - $signed({1'b0, pb});
  assign gy = $signed({1'b0, cur_pix}) - $signed({1'b0, pix_rd});
  assign w_start = (state == S_RD) && (rd_cnt == 2'd3);
  assign d_start = (state == S_MAC) && (tap == 4'd11);
  assign wt_eff = wz1 ? '0 : wt_rd;

  always_comb begin
    drl_n[0] = er;
    drl_n[1] = rows_m1;
    drl_n[2] = rows_m1;
    nr_last_n = 2'd0;
    if (er == ROW_W'(1)) begin
      drl_n[0] = '0;
      drl_n[1] = er;
      nr_last_n = (er == rows_m2) ? 2'd2 : 2'd1;
    end else if (er == rows_m2) begin
      nr_last_n = 2'd1;
    end
    dcl_n[0] = ec;
    dcl_n[1] = COL_W'(IMAGE_WIDTH - 1);
    nc_last_n = 1'b0;
    if (ec == COL_W'(1)) begin
      dcl_n[0] = '0;
      dcl_n[1] = ec;
      nc_last_n = 1'b1;
    end else if (ec == COL_W'(IMAGE_WIDTH - 2)) begin
      nc_last_n = 1'b1;
    end
  end

  assign push_valid = (state == S_PUSH);
  assign push_data = '{row: drl[pi], col: dcl[pj], val: val};

  assign result_valid = (state == S_DRAIN) && (qcount != '0);
  assign res_acc = result_valid && !result_stall;
  assign last_of_run = (dcount == 2'd3) || (qcount == QUEUE_CW'(1));
  assign out_row = head_data.row;
  assign out_col = OUT_COL_W'(head_data.col);
  assign smoothed = head_data.val;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= ROWS_RESET;
    end else if (wr_en) begin
      image_rows <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row_count <= '0;
      col_count <= '0;
      emit_a <= 1'b0;
      emit_b <= 1'b0;
      rd_cnt <= '0;
      tap <= '0;
      dcount <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pix_acc) begin
            y <= y0;
            x <= x0;
            cur_pix <= pixel;
            emit_a <= (x0 >= COL_W'(2)) && (y0 >= ROW_W'(3)) && (y0 <= rows_m1);
            emit_b <= (x0 >= COL_W'(2)) && (y0 == rows_m1);
            if (last_col) begin
              col_count <= '0;
              row_count <= (y0 >= rows_m1) ? '0 : y0 + ROW_W'(1);
            end else begin
              col_count <= x0 + COL_W'(1);
              row_count <= y0;
            end
            rd_cnt <= '0;
            wt_val <= '0;
            if (y0 == '0) begin
              state <= S_ESEL;
            end else if (calc0) begin
              state <= S_RD;
            end else begin
              state <= S_WWR;
            end
          end
        end
        S_RD: begin
          rd_cnt <= rd_cnt + 2'd1;
          if (rd_cnt == 2'd1) begin
            pa <= pix_rd;
          end
          if (rd_cnt == 2'd2) begin
            pb <= pix_rd;
          end
          if (rd_cnt == 2'd3) begin
            state <= S_WCALC;
          end
        end
        S_WCALC: begin
          if (w_done) begin
            wt_val <= w_out;
            state <= S_WWR;
          end
        end
        S_WWR: begin
          state <= S_ESEL;
        end
        S_ESEL: begin
          tap <= '0;
          ti <= '0;
          tj <= '0;
          num <= '0;
          den <= '0;
          dcount <= '0;
          if (emit_a) begin
            er <= ym2;
            emit_a <= 1'b0;
            state <= S_MAC;
          end else if (emit_b) begin
            er <= rows_m2;
            emit_b <= 1'b0;
            state <= S_MAC;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_MAC: begin
          tap <= tap + 4'd1;
          if (tap <= 4'd8) begin
            wz1 <= wz_now;
            if (tj == 2'd2) begin
              tj <= '0;
              ti <= ti + 2'd1;
            end else begin
              tj <= tj + 2'd1;
            end
          end
          if (tap >= 4'd1 && tap <= 4'd9) begin
            prod <= 40'(wt_eff) * 40'(pix_rd);
            wq <= wt_eff;
          end
          if (tap >= 4'd2 && tap <= 4'd10) begin
            num <= num + NUM_W'(prod);
            den <= den + DEN_W'(wq);
          end
          if (tap == 4'd11) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (d_done) begin
            val <= d_quot;
            drl <= drl_n;
            dcl <= dcl_n;
            nr_last <= nr_last_n;
            nc_last <= nc_last_n;
            pi <= '0;
            pj <= 1'b0;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (pj == nc_last) begin
            pj <= 1'b0;
            if (pi == nr_last) begin
              state <= S_ESEL;
            end else begin
              pi <= pi + 2'd1;
            end
          end else begin
            pj <= 1'b1;
          end
        end
        S_DRAIN: begin
          if (qcount == '0) begin
            state <= S_IDLE;
          end else if (res_acc) begin
            dcount <= dcount + 2'd1;
            if (last_of_run) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  gws_weight u_weight (
    .clk    (clk),
    .rst    (rst),
    .start  (w_start),
    .gx     (gx),
    .gy     (gy),
    .done   (w_done),
    .weight (w_out)
  );

  gws_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (d_start),
    .num   (num),
    .den   (den),
    .done  (d_done),
    .quot  (d_quot)
  );

  gws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (res_acc),
    .head_data  (head_data),
    .count      (qcount)
  );

  a_stall_after_beat: assert property (@(posedge clk) disable iff (rst)
    pix_acc |=> pixel_stall)
    else $error("pixel beat taken while the previous one is still in work");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (res_acc && last_of_run) |=> !result_valid)
    else $error("result run continues past its last beat");

  a_no_push_in_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !push_valid)
    else $error("result queue written during the output phase");

  a_weight_write_idle: assert property (@(posedge clk) disable iff (rst)
    wt_we |-> (!pix_acc && !w_start && !d_start))
    else $error("weight line write overlaps another phase");

endmodule

// ----- sv/gws_weight.sv -----
module gws_weight import gws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic signed [8:0] gx,
  input  logic signed [8:0] gy,
  output logic              done,
  output logic [WT_W-1:0]   weight
);

  typedef enum logic [8:0] {
    W_IDLE = 9'b000000001,
    W_SQRT = 9'b000000010,
    W_LOG  = 9'b000000100,
    W_RND  = 9'b000001000,
    W_LN   = 9'b000010000,
    W_INIT = 9'b000100000,
    W_TMUL = 9'b001000000,
    W_TDIV = 9'b010000000,
    W_FIN  = 9'b100000000
  } wstate_t;

  wstate_t state;

  logic signed [17:0] gx2, gy2;
  logic [17:0] s_full;
  logic [16:0] s_in;

  logic [49:0] op;
  logic [26:0] rem, rem_n;
  logic [24:0] root, root_n;
  logic [28:0] sq_r2;
  logic [26:0] sq_trial;
  logic [4:0]  sq_cnt;
  logic        pass2;

  logic [55:0] prod, ysum;
  logic [9:0]  kreg;
  logic [15:0] greg;
  logic [47:0] xprod;
  logic [31:0] xreg;
  logic [31:0] t;
  logic [63:0] tprod;
  logic [33:0] tsum;
  logic [3:0]  tidx;
  logic [31:0] dv, dv_n, d_c;
  logic [3:0]  drem, drem_n, r_c;
  logic [4:0]  r2;
  logic [2:0]  dcnt;

  logic [34:0] half, tot, wv;
  logic [WT_W-1:0] w_fin;

  assign gx2 = gx * gx;
  assign gy2 = gy * gy;
  assign s_full = $unsigned(gx2) + $unsigned(gy2);
  assign s_in = s_full[16:0];

  always_comb begin
    sq_r2 = {rem, op[49:48]};
    sq_trial = {root, 2'b01};
    if (sq_r2 >= {2'b00, sq_trial}) begin
      rem_n = 27'(sq_r2 - {2'b00, sq_trial});
      root_n = {root[23:0], 1'b1};
    end else begin
      rem_n = sq_r2[26:0];
      root_n = {root[23:0], 1'b0};
    end
  end

  assign ysum = prod + 56'(2 ** 29);
  assign xprod = 48'(greg) * 48'(LN2_Q32);
  assign tprod = 64'(t) * 64'(xreg);

  always_comb begin
    r_c = drem;
    d_c = dv;
    r2 = '0;
    for (int b = 0; b < 4; b++) begin
      r2 = {r_c, d_c[31]};
      d_c = {d_c[30:0], 1'b0};
      if (r2 >= {1'b0, tidx}) begin
        r_c = 4'(r2 - {1'b0, tidx});
        d_c[0] = 1'b1;
      end else begin
        r_c = r2[3:0];
      end
    end
    drem_n = r_c;
    dv_n = d_c;
  end

  always_comb begin
    half = (35'd1 << kreg[5:0]) >> 1;
    tot = {1'b0, tsum} + half;
    wv = tot >> kreg[5:0];
    if (kreg > 10'd33) begin
      w_fin = '0;
    end else if (|wv[34:32]) begin
      w_fin = '1;
    end else begin
      w_fin = wv[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        W_IDLE: begin
          if (start) begin
            op <= {1'b0, s_in, 32'd0};
            rem <= '0;
            root <= '0;
            sq_cnt <= '0;
            pass2 <= 1'b0;
            state <= W_SQRT;
          end
        end
        W_SQRT: begin
          op <= op << 2;
          rem <= rem_n;
          root <= root_n;
          if (sq_cnt == 5'd24) begin
            if (!pass2) begin
              op <= {9'd0, root_n, 16'd0};
              rem <= '0;
              root <= '0;
              sq_cnt <= '0;
              pass2 <= 1'b1;
            end else begin
              state <= W_LOG;
            end
          end else begin
            sq_cnt <= sq_cnt + 5'd1;
          end
        end
        W_LOG: begin
          prod <= 56'(root) * 56'(LOG2E_Q30);
          state <= W_RND;
        end
        W_RND: begin
          kreg <= ysum[55:46];
          greg <= ysum[45:30];
          state <= W_LN;
        end
        W_LN: begin
          xreg <= xprod[47:16];
          state <= W_INIT;
        end
        W_INIT: begin
          t <= xreg;
          tsum <= ONE_Q32 - 34'(xreg);
          tidx <= 4'd2;
          state <= W_TMUL;
        end
        W_TMUL: begin
          dv <= tprod[63:32];
          drem <= '0;
          dcnt <= '0;
          state <= W_TDIV;
        end
        W_TDIV: begin
          dv <= dv_n;
          drem <= drem_n;
          dcnt <= dcnt + 3'd1;
          if (dcnt == 3'd7) begin
            t <= dv_n;
            tsum <= tidx[0] ? tsum - 34'(dv_n) : tsum + 34'(dv_n);
            if (tidx == 4'd13) begin
              state <= W_FIN;
            end else begin
              tidx <= tidx + 4'd1;
              state <= W_TMUL;
            end
          end
        end
        W_FIN: begin
          weight <= w_fin;
          done <= 1'b1;
          state <= W_IDLE;
        end
        default: begin
          state <= W_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/gws_div.sv -----
module gws_div import gws_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [VAL_W-1:0] quot
);

  logic [53:0] nfull;
  logic [36:0] dd;
  logic [37:0] rem, rem_n;
  logic [38:0] r2;
  logic [VAL_W-1:0] lo, lo_n;
  logic zero;
  logic busy;
  logic [3:0] cnt;

  assign nfull = {1'b0, num, 9'd0} + 54'(den);

  always_comb begin
    r2 = {rem, lo[VAL_W-1]};
    if (r2 >= 39'(dd)) begin
      rem_n = 38'(r2 - 39'(dd));
      lo_n = {lo[VAL_W-2:0], 1'b1};
    end else begin
      rem_n = r2[37:0];
      lo_n = {lo[VAL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= nfull[53:16];
        lo <= nfull[15:0];
        dd <= {den, 1'b0};
        zero <= (den == '0);
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_n;
        lo <= lo_n;
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= zero ? '0 : lo_n;
        end
      end
    end
  end

endmodule

// ----- sv/gws_queue.sv -----
module gws_queue import gws_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  result_t             push_data,
  input  logic                pop,
  output result_t             head_data,
  output logic [QUEUE_CW-1:0] count
);

  result_t entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] head;
  logic push_ok, pop_ok;

  assign push_ok = push_valid && (count < QUEUE_CW'(QUEUE_DEPTH));
  assign pop_ok = pop && (count != '0);
  assign head_data = entries[head];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[QUEUE_AW'(head + count[QUEUE_AW-1:0])] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
    end else begin
      if (pop_ok) begin
        head <= head + QUEUE_AW'(1);
      end
      count <= count + QUEUE_CW'(push_ok) - QUEUE_CW'(pop_ok);
    end
  end

endmodule

// ----- verif/gradient_weighted_smoothing_3x3_tb.sv -----
module gradient_weighted_smoothing_3x3_tb;
  import gws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_OFF_CYCLES = 3000;

  typedef struct {
    bit [ROW_W-1:0]     row;
    bit [OUT_COL_W-1:0] col;
    bit [VAL_W-1:0]     val;
    bit                 last;
  } smoothed_beat_t;

  typedef struct {
    bit [PIX_W-1:0] value;
    bit             sof;
    bit             quiet;
  } pixel_row_t;

  logic                  clk;
  logic                  rst;
  logic                  pixel_valid;
  logic                  pixel_stall;
  logic [PIX_W-1:0]      pixel;
  logic                  frame_start;
  logic                  result_valid;
  logic                  result_stall;
  logic [ROW_W-1:0]      out_row;
  logic [OUT_COL_W-1:0]  out_col;
  logic [VAL_W-1:0]      smoothed;
  logic                  last_of_run;
  logic                  wr_en;
  logic [ROWS_CFG_W-1:0] wr_data;

  gradient_weighted_smoothing_3x3 DUT (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel(pixel), .frame_start(frame_start),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_row(out_row), .out_col(out_col), .smoothed(smoothed), .last_of_run(last_of_run),
    .wr_en(wr_en), .wr_data(wr_data)
  );

  bit [PIX_W-1:0] line_pixels [4][IMAGE_WIDTH];
  bit [WT_W-1:0]  line_weights [4][IMAGE_WIDTH];
  int unsigned    rows_setting;
  int unsigned    next_row;
  int unsigned    next_col;
  smoothed_beat_t held_results[$];
  smoothed_beat_t awaited_results[$];

  bit failed;
  int unsigned cycles;
  int unsigned results_seen;
  int unsigned burst_left;
  int unsigned content_mode;
  int unsigned content_level;

  pixel_row_t directed_rows[] = '{
    '{8'd0,   1'b1, 1'b1}, '{8'd255, 1'b0, 1'b1}, '{8'd0,   1'b0, 1'b1},
    '{8'd255, 1'b0, 1'b1}, '{8'd1,   1'b0, 1'b1}, '{8'd128, 1'b0, 1'b1},
    '{8'd127, 1'b0, 1'b1}, '{8'h55,  1'b0, 1'b1}, '{8'hAA,  1'b0, 1'b1},
    '{8'd254, 1'b1, 1'b1}, '{8'd0,   1'b0, 1'b1}, '{8'd0,   1'b0, 1'b1},
    '{8'd0,   1'b0, 1'b1}, '{8'd255, 1'b0, 1'b1}, '{8'd255, 1'b0, 1'b1},
    '{8'd255, 1'b0, 1'b1}, '{8'h0F,  1'b0, 1'b1}, '{8'hF0,  1'b0, 1'b1}
  };

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit [WT_W-1:0] edge_weight(int gx, int gy);
    longint unsigned s, a, q, y, k, g, x, t, sum, w;
    s = longint'(gx * gx + gy * gy);
    a = int_sqrt(s << 32);
    q = int_sqrt(a << 16);
    y = (q * 64'(LOG2E_Q30) + (64'd1 << 29)) >> 30;
    k = y >> 16;
    g = y & 64'hFFFF;
    x = (g * 64'(LN2_Q32)) >> 16;
    t = 64'd1 << 32;
    sum = t;
    for (int i = 1; i <= 13; i++) begin
      t = ((t * x) >> 32) / i;
      if (i % 2 == 1) sum -= t; else sum += t;
    end
    if (k > 33) return '0;
    w = (sum + ((64'd1 << k) >> 1)) >> k;
    if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
    return w[WT_W-1:0];
  endfunction

  function automatic longint unsigned weight_at(int unsigned r, int unsigned c,
                                                int unsigned rows);
    if (r == 0 || r >= rows - 1 || c == 0 || c >= IMAGE_WIDTH - 1) return 0;
    return line_weights[r % 4][c];
  endfunction

  function automatic bit [VAL_W-1:0] smooth_at(int unsigned r, int unsigned c,
                                               int unsigned rows);
    longint unsigned num, den, w;
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        w = weight_at(r + i - 1, c + j - 1, rows);
        den += w;
        num += w * line_pixels[(r + i - 1) % 4][(c + j - 1) % IMAGE_WIDTH];
      end
    end
    if (den == 0) return '0;
    return VAL_W'((num * 512 + den) / (2 * den));
  endfunction

  function automatic void queue_smoothed(int unsigned r, int unsigned c, int unsigned rows);
    bit [VAL_W-1:0] v;
    int unsigned dr[$], dc[$];
    smoothed_beat_t b;
    v = smooth_at(r, c, rows);
    if (r == 1) dr.push_back(0);
    dr.push_back(r);
    if (r == rows - 2) dr.push_back(rows - 1);
    if (c == 1) dc.push_back(0);
    dc.push_back(c);
    if (c == IMAGE_WIDTH - 2) dc.push_back(IMAGE_WIDTH - 1);
    foreach (dr[i]) begin
      foreach (dc[j]) begin
        b.row = dr[i];
        b.col = dc[j];
        b.val = v;
        b.last = 1'b0;
        held_results.push_back(b);
      end
    end
  endfunction

  function automatic int advance_raster(bit [PIX_W-1:0] p, bit sof, ref smoothed_beat_t outs[$]);
    int unsigned rows, y, x;
    int gx, gy;
    bit [WT_W-1:0] w;
    rows = rows_setting;
    if (rows < 3) rows = 3;
    if (rows > 4096) rows = 4096;
    if (sof) begin
      next_row = 0;
      next_col = 0;
    end
    y = next_row;
    x = next_col;
    line_pixels[y % 4][x] = p;
    if (y >= 1) begin
      w = '0;
      if (y - 1 >= 1 && y - 1 <= rows - 2 && x >= 1 && x <= IMAGE_WIDTH - 2) begin
        gx = int'(line_pixels[(y - 1) % 4][x + 1]) - int'(line_pixels[(y - 1) % 4][x - 1]);
        gy = int'(line_pixels[y % 4][x]) - int'(line_pixels[(y - 2) % 4][x]);
        w = edge_weight(gx, gy);
      end
      line_weights[(y - 1) % 4][x] = w;
    end
    if (x >= 2) begin
      if (y >= 3 && y <= rows - 1) queue_smoothed(y - 2, x - 1, rows);
      if (y == rows - 1) queue_smoothed(rows - 2, x - 1, rows);
    end
    x++;
    if (x >= IMAGE_WIDTH) begin
      x = 0;
      if (y >= rows - 1) y = 0; else y = (y + 1) % 4096;
    end
    next_row = y;
    next_col = x;
    outs.delete();
    while (held_results.size() > 0 && outs.size() < 4) outs.push_back(held_results.pop_front());
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    return outs.size();
  endfunction

  task automatic pause(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      pixel_valid <= 1'b0;
    end
  endtask

  task automatic send_beat(bit [PIX_W-1:0] p, bit sof, bit quiet);
    smoothed_beat_t outs[$];
    int n;
    @(negedge clk);
    pixel_valid <= 1'b1;
    pixel <= p;
    frame_start <= sof;
    forever begin
      @(posedge clk);
      if (!pixel_stall) break;
    end
    n = advance_raster(p, sof, outs);
    if (quiet && n != 0) begin
      $display("%0t: pixel %0d expected no smoothed beat, predicted %0d", $time, p, n);
      failed = 1'b1;
    end
    foreach (outs[i]) awaited_results.push_back(outs[i]);
  endtask

  task automatic offer(bit [PIX_W-1:0] p, bit sof);
    if (burst_left == 0) begin
      if ($urandom_range(0, 15) == 0) pause($urandom_range(50, 300));
      else pause($urandom_range(0, 6));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_beat(p, sof, 1'b0);
  endtask

  task automatic write_rows(bit [ROWS_CFG_W-1:0] v);
    pause(1);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_data <= v;
    @(negedge clk);
    wr_en <= 1'b0;
    rows_setting = v;
  endtask

  function automatic bit [PIX_W-1:0] next_pixel(int unsigned idx);
    if (idx % 32 == 0) begin
      content_mode = $urandom_range(0, 3);
      content_level = $urandom_range(0, 255);
    end
    case (content_mode)
      0: return $urandom_range(0, 255);
      1: return content_level;
      2: return (idx % 2 == 0) ? 8'd0 : 8'd255;
      default: begin
        int v;
        v = int'(content_level) + int'($urandom_range(0, 8)) - 4;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    smoothed_beat_t e;
    if (!rst && result_valid && !result_stall) begin
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected beat row %0d col %0d val %0h", $time,
                 out_row, out_col, smoothed);
        failed = 1'b1;
      end else begin
        e = awaited_results.pop_front();
        if (out_row !== e.row) begin
          $display("%0t: out_row expected %0d actual %0d", $time, e.row, out_row);
          failed = 1'b1;
        end
        if (out_col !== e.col) begin
          $display("%0t: out_col expected %0d actual %0d", $time, e.col, out_col);
          failed = 1'b1;
        end
        if (smoothed !== e.val) begin
          $display("%0t: smoothed expected %0h actual %0h", $time, e.val, smoothed);
          failed = 1'b1;
        end
        if (last_of_run !== e.last) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, e.last, last_of_run);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    bit held_off;
    int unsigned span, mode;
    result_stall = 1'b0;
    held_off = 1'b0;
    forever begin
      if (!held_off && results_seen >= 200) begin
        held_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk);
          result_stall <= 1'b1;
        end
      end
      span = $urandom_range(10, 200);
      mode = $urandom_range(0, 2);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= $urandom_range(0, 1);
          default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel = '0;
    frame_start = 1'b0;
    wr_en = 1'b0;
    wr_data = '0;
    failed = 1'b0;
    cycles = 0;
    results_seen = 0;
    burst_left = 0;
    content_mode = 0;
    content_level = 0;
    rows_setting = ROWS_RESET;
    next_row = 0;
    next_col = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_rows(13'd0);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].value, directed_rows[i].sof, directed_rows[i].quiet);
    write_rows(ROWS_MIN);

    for (int i = 0; i < 3 * IMAGE_WIDTH; i++) offer(next_pixel(i), i == 0);
    for (int i = 0; i < 24; i++) offer(next_pixel(i), $urandom_range(0, 7) == 0);

    write_rows(13'h1FFF);
    for (int i = 0; i < 12; i++) offer($urandom_range(0, 255), $urandom_range(0, 5) == 0);
    write_rows(ROWS_MAX);
    for (int i = 0; i < 12; i++) offer($urandom_range(0, 255), $urandom_range(0, 5) == 0);
    write_rows(ROWS_MIN);
    for (int i = 0; i < 8; i++) offer($urandom_range(0, 255), i == 0);

    pause(1);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/gws_pkg.sv
sv/gws_weight.sv
sv/gws_div.sv
sv/gws_queue.sv
sv/gradient_weighted_smoothing_3x3.sv
verif/gradient_weighted_smoothing_3x3_tb.sv
